/* sv/dts_pkg.sv */
`default_nettype none
package dts_pkg;

   // Graph size limit and derived widths
   localparam int NODE_LIMIT = 64;
   localparam int NODE_W     = $clog2(NODE_LIMIT);
   localparam int CNT_W      = $clog2(NODE_LIMIT + 1);

   // Fixed field widths
   localparam int EDGE_W = 6;
   localparam int CFG_W  = 7;

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

   // Request kinds
   localparam logic REQ_ADD_EDGE = 1'b0;
   localparam logic REQ_SORT     = 1'b1;

   // Adjacency read address select
   localparam logic [1:0] ADJ_SEL_EDGE  = 2'd0;
   localparam logic [1:0] ADJ_SEL_ROOT  = 2'd1;
   localparam logic [1:0] ADJ_SEL_CHILD = 2'd2;
   localparam logic [1:0] ADJ_SEL_STACK = 2'd3;

   typedef struct packed {
      logic       latch_req;
      logic       sort_init;
      logic       edge_wr;
      logic       start_root;
      logic       push;
      logic       pop;
      logic       load_top;
      logic       emit_init;
      logic       emit_rd;
      logic       clear_adj;
      logic [1:0] adj_sel;
   } dts_cmd_type;

   typedef struct packed {
      logic is_sort;
      logic edge_ok;
      logic can_push;
      logic depth_one;
      logic all_visited;
      logic emit_last;
   } dts_stat_type;

   // Index of the lowest set bit, zero when none is set
   function automatic logic [NODE_W-1:0] lowest_set(input logic [NODE_LIMIT-1:0] v);
      logic [NODE_W-1:0] idx;
      idx = '0;
      for (int j = NODE_LIMIT - 1; j >= 0; j--) begin
         if (v[j]) idx = NODE_W'(j);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

/* sv/dts_ctrl.sv */
`default_nettype none
module dts_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire dts_pkg::dts_stat_type stat,
   output dts_pkg::dts_cmd_type       cmd,
   output logic                       busy
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_EDGE_RD = 3'd1;
   localparam logic [2:0] ST_EDGE_WR = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_CHECK   = 3'd4;
   localparam logic [2:0] ST_POP     = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;
   localparam logic [2:0] ST_DRAIN   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.adj_sel = dts_pkg::ADJ_SEL_EDGE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               if (stat.is_sort) begin
                  cmd.sort_init = 1'b1;
                  state_in      = ST_SCAN;
               end else if (stat.edge_ok) begin
                  state_in = ST_EDGE_RD;
               end
            end
         end
         ST_EDGE_RD: begin
            cmd.adj_sel = dts_pkg::ADJ_SEL_EDGE;
            state_in    = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.all_visited) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.start_root = 1'b1;
               cmd.adj_sel    = dts_pkg::ADJ_SEL_ROOT;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.can_push) begin
               cmd.push    = 1'b1;
               cmd.adj_sel = dts_pkg::ADJ_SEL_CHILD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = stat.depth_one ? ST_SCAN : ST_POP;
            end
         end
         ST_POP: begin
            cmd.load_top = 1'b1;
            cmd.adj_sel  = dts_pkg::ADJ_SEL_STACK;
            state_in     = ST_CHECK;
         end
         ST_EMIT: begin
            cmd.emit_rd = 1'b1;
            if (stat.emit_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.clear_adj = 1'b1;
            state_in      = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

/* sv/dts_datapath.sv */
`default_nettype none
module dts_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_type,
   input  wire logic [dts_pkg::EDGE_W-1:0]    req_edge_from,
   input  wire logic [dts_pkg::EDGE_W-1:0]    req_edge_to,
   input  wire logic                          csr_wr_en,
   input  wire logic [dts_pkg::CFG_W-1:0]     csr_wr_data,
   input  wire dts_pkg::dts_cmd_type          cmd,
   output dts_pkg::dts_stat_type              stat,
   output logic                               rsp_valid,
   output logic [dts_pkg::EDGE_W-1:0]         rsp_order_node,
   output logic                               rsp_order_last
);

   localparam int NL = dts_pkg::NODE_LIMIT;
   localparam int NW = dts_pkg::NODE_W;
   localparam int CW = dts_pkg::CNT_W;

   logic [dts_pkg::CFG_W-1:0] node_count_ff;
   logic [CW-1:0]             n_eff;
   logic [NL-1:0]             live_mask;

   logic [NL-1:0] adj_mem_ff [NL];
   logic [NL-1:0] adj_valid_ff;
   logic [NL-1:0] adj_valid_in;
   logic [NL-1:0] adj_rd_ff;
   logic          adj_rd_valid_ff;
   logic [NL-1:0] row_eff;
   logic [NL-1:0] cand;
   logic [NL-1:0] edge_row;
   logic [NW-1:0] adj_addr;

   logic [NW-1:0] stack_mem_ff [NL];
   logic [NW-1:0] stack_rd_ff;
   logic [NW-1:0] order_mem_ff [NL];
   logic [NW-1:0] order_rd_ff;

   logic [NL-1:0] visited_ff;
   logic [NL-1:0] visited_in;
   logic [NW-1:0] top_ff;
   logic [NW-1:0] top_in;
   logic [CW-1:0] depth_ff;
   logic [CW-1:0] depth_in;
   logic [CW-1:0] wpos_ff;
   logic [CW-1:0] wpos_in;
   logic [NW-1:0] emit_idx_ff;
   logic [NW-1:0] emit_idx_in;
   logic [CW-1:0] depth_less_one;
   logic [CW-1:0] depth_less_two;

   logic [NW-1:0] edge_from_ff;
   logic [NW-1:0] edge_to_ff;
   logic [NW-1:0] child;
   logic [NW-1:0] root;

   logic rsp_valid_ff;
   logic rsp_last_ff;

   // Effective count: saturate into one to the node limit
   always_comb begin
      if (node_count_ff == '0)
         n_eff = CW'(1);
      else if (node_count_ff > dts_pkg::CFG_W'(NL))
         n_eff = CW'(NL);
      else
         n_eff = CW'(node_count_ff);
   end

   always_comb begin
      for (int j = 0; j < NL; j++) live_mask[j] = (CW'(j) < n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset)          node_count_ff <= dts_pkg::NODE_COUNT_RESET;
      else if (csr_wr_en) node_count_ff <= csr_wr_data;
   end

   // Search candidates from the row just read
   assign row_eff        = adj_rd_valid_ff ? adj_rd_ff : '0;
   assign cand           = row_eff & ~visited_ff & live_mask;
   assign child          = dts_pkg::lowest_set(cand);
   assign root           = dts_pkg::lowest_set(~visited_ff & live_mask);
   assign depth_less_one = depth_ff - CW'(1);
   assign depth_less_two = depth_ff - CW'(2);

   always_comb begin
      stat.is_sort     = (req_type == dts_pkg::REQ_SORT);
      stat.edge_ok     = (CW'(req_edge_from) < n_eff) && (CW'(req_edge_to) < n_eff);
      stat.can_push    = (cand != '0) && (depth_ff < CW'(NL));
      stat.depth_one   = (depth_ff == CW'(1));
      stat.all_visited = ((~visited_ff & live_mask) == '0);
      stat.emit_last   = (CW'(emit_idx_ff) == n_eff - CW'(1));
   end

   always_comb begin
      unique case (cmd.adj_sel)
         dts_pkg::ADJ_SEL_EDGE:  adj_addr = edge_from_ff;
         dts_pkg::ADJ_SEL_ROOT:  adj_addr = root;
         dts_pkg::ADJ_SEL_CHILD: adj_addr = child;
         dts_pkg::ADJ_SEL_STACK: adj_addr = stack_rd_ff;
      endcase
   end

   // Merge the new edge into the row; a row never written reads as zero
   assign edge_row = row_eff | (NL'(1) << edge_to_ff);

   always_ff @(posedge clock) begin
      adj_rd_ff       <= adj_mem_ff[adj_addr];
      adj_rd_valid_ff <= adj_valid_ff[adj_addr];
      if (cmd.edge_wr) adj_mem_ff[edge_from_ff] <= edge_row;
   end

   always_comb begin
      adj_valid_in = adj_valid_ff;
      if (cmd.clear_adj)    adj_valid_in = '0;
      else if (cmd.edge_wr) adj_valid_in[edge_from_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) adj_valid_ff <= '0;
      else       adj_valid_ff <= adj_valid_in;
   end

   // Stack below the top entry, top kept in a register
   always_ff @(posedge clock) begin
      stack_rd_ff <= stack_mem_ff[depth_less_two[NW-1:0]];
      if (cmd.push) stack_mem_ff[depth_less_one[NW-1:0]] <= top_ff;
   end

   always_ff @(posedge clock) begin
      order_rd_ff <= order_mem_ff[emit_idx_ff];
      if (cmd.pop) order_mem_ff[wpos_ff[NW-1:0]] <= top_ff;
   end

   always_comb begin
      visited_in  = visited_ff;
      top_in      = top_ff;
      depth_in    = depth_ff;
      wpos_in     = wpos_ff;
      emit_idx_in = emit_idx_ff;
      if (cmd.sort_init) begin
         visited_in = '0;
         depth_in   = '0;
         wpos_in    = n_eff - CW'(1);
      end
      if (cmd.start_root) begin
         visited_in = visited_ff | (NL'(1) << root);
         top_in     = root;
         depth_in   = CW'(1);
      end
      if (cmd.push) begin
         visited_in = visited_ff | (NL'(1) << child);
         top_in     = child;
         depth_in   = depth_ff + CW'(1);
      end
      if (cmd.pop) begin
         depth_in = depth_less_one;
         wpos_in  = wpos_ff - CW'(1);
      end
      if (cmd.load_top)  top_in      = stack_rd_ff;
      if (cmd.emit_init) emit_idx_in = '0;
      if (cmd.emit_rd)   emit_idx_in = emit_idx_ff + NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff   <= '0;
         depth_ff     <= '0;
         wpos_ff      <= CW'(NL - 1);
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         wpos_ff      <= wpos_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= cmd.emit_rd;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.emit_rd) rsp_last_ff <= stat.emit_last;
      if (cmd.latch_req) begin
         edge_from_ff <= NW'(req_edge_from);
         edge_to_ff   <= NW'(req_edge_to);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_order_node = dts_pkg::EDGE_W'(order_rd_ff);
   assign rsp_order_last = rsp_last_ff;

endmodule
`default_nettype wire

/* sv/dfs_topological_sort.sv */
`default_nettype none
// Depth-first topological sort over an adjacency bit matrix.
// Request channel: drive req_type, req_edge_from and req_edge_to with start
// high; the transfer happens at a rising edge where busy is low. An add-edge
// request sets one matrix bit and keeps busy high through a row read state
// and a row write state; an edge with an endpoint at or above the effective
// node count is dropped and busy stays low. A sort request searches the
// graph and then emits N = effective node count results, one per cycle on
// consecutive cycles, each marked by rsp_valid for exactly one cycle;
// rsp_order_last flags the final one. The receiver cannot stall: every
// strobe is a completed transfer. Sort steps: each push is made in the check
// state, each pop passes the check and pop states (only the check when it
// closes a tree), a scan state opens each search tree and a last scan ends
// the search, then the emit state sends the results and a drain state
// clears the matrix. The search loop is paced by the registered read of the
// adjacency row memory feeding the priority encoder.
// Config: csr_wr_en with csr_wr_data writes node_count; write only while
// busy is low. Reset (synchronous) empties the matrix, sets node_count to 64
// and returns to idle; no clearing pass is needed.
module dfs_topological_sort (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_type,
   input  wire logic [dts_pkg::EDGE_W-1:0] req_edge_from,
   input  wire logic [dts_pkg::EDGE_W-1:0] req_edge_to,
   output logic                            rsp_valid,
   output logic [dts_pkg::EDGE_W-1:0]      rsp_order_node,
   output logic                            rsp_order_last,
   input  wire logic                       csr_wr_en,
   input  wire logic [dts_pkg::CFG_W-1:0]  csr_wr_data
);

   // Command and status between the sequencer and the datapath
   dts_pkg::dts_cmd_type  cmd;
   dts_pkg::dts_stat_type stat;

   // Sequencer: accepts requests and steps the search one push or pop a time
   dts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Datapath: matrix rows, stack and order memories, visited marks
   dts_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_edge_from  (req_edge_from),
      .req_edge_to    (req_edge_to),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_order_node (rsp_order_node),
      .rsp_order_last (rsp_order_last)
   );

endmodule
`default_nettype wire

/* sv/dts_checker.sv */
`default_nettype none
module dts_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       req_type,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_order_last
);

   // Results only come while a request is in progress
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // An add-edge transfer never yields a result next cycle
   a_edge_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == dts_pkg::REQ_ADD_EDGE)) |=> !rsp_valid)
      else $error("result after add-edge request");

   // Emission is a contiguous burst ending with the last flag
   a_burst_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_order_last) |=> rsp_valid)
      else $error("gap inside result burst");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_order_last) |=> !rsp_valid)
      else $error("result after last flag");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

endmodule

bind dfs_topological_sort dts_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_type       (req_type),
   .rsp_valid      (rsp_valid),
   .rsp_order_last (rsp_order_last)
);
`default_nettype wire
